// ===== rtl/tbrl_pkg.sv =====
package tbrl_pkg;

	localparam int TOKEN_FRAC_BITS = 8;
	localparam int BYTE_W = 32;
	localparam int STORE_W = BYTE_W + TOKEN_FRAC_BITS;
	localparam int WAIT_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = STORE_W;
	localparam int DIV_CNT_W = $clog2(STORE_W + 1);
	localparam int OUT_DATA_W = ((2 * BYTE_W + 1 + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] REG_RATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFILL = 1'd1;

	localparam logic [STORE_W-1:0] REFILL_RESET = STORE_W'(256);
	localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

	typedef enum logic {
		REQ_TICK,
		REQ_CONSUME
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CMP,
		ST_DIV,
		ST_CEIL,
		ST_SUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               start;
		logic [STORE_W-1:0] dividend;
		logic [STORE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [STORE_W-1:0] quotient;
		logic               rem_nz;
	} div_rsp_t;

	typedef struct packed {
		logic              holding;
		logic [BYTE_W-1:0] token_level;
		logic [WAIT_W-1:0] wait_ticks;
	} result_t;

endpackage

// ===== rtl/tbrl_div.sv =====
module tbrl_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tbrl_pkg::div_req_t req,
	output tbrl_pkg::div_rsp_t rsp
);

	logic [tbrl_pkg::STORE_W-1:0]   dvs_q;
	logic [tbrl_pkg::STORE_W-1:0]   quo_q;
	logic [tbrl_pkg::STORE_W-1:0]   rem_q;
	logic [tbrl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [tbrl_pkg::STORE_W:0]     shifted;
	logic [tbrl_pkg::STORE_W:0]     diff;
	logic                           ge;

	// one quotient bit per cycle, restoring
	always_comb begin
		shifted = {rem_q, quo_q[tbrl_pkg::STORE_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tbrl_pkg::DIV_CNT_W'(tbrl_pkg::STORE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tbrl_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[tbrl_pkg::STORE_W-1:0] : shifted[tbrl_pkg::STORE_W-1:0];
			quo_q <= {quo_q[tbrl_pkg::STORE_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.rem_nz   = |rem_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("divider did not start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && cnt_q == '0))
		else $error("divider done while still counting");

endmodule

// ===== rtl/tbrl_core.sv =====
module tbrl_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  tbrl_pkg::req_kind_t                in_kind,
	input  logic [tbrl_pkg::BYTE_W-1:0]        in_bytes,
	input  logic [tbrl_pkg::BYTE_W-1:0]        rate,
	input  logic [tbrl_pkg::STORE_W-1:0]       refill,
	output logic                               res_valid,
	input  logic                               res_ready,
	output tbrl_pkg::result_t                  res
);

	tbrl_pkg::state_t              state_q, state_d;
	tbrl_pkg::req_kind_t           kind_q;
	logic [tbrl_pkg::STORE_W-1:0]  need_q;
	logic [tbrl_pkg::STORE_W-1:0]  store_q;
	logic [tbrl_pkg::WAIT_W-1:0]   hold_q;
	logic [tbrl_pkg::WAIT_W-1:0]   wait_q;
	logic [tbrl_pkg::STORE_W:0]    ceil_q;

	logic [tbrl_pkg::STORE_W-1:0]  cap;
	logic [tbrl_pkg::STORE_W:0]    refill_sum;
	logic [tbrl_pkg::STORE_W-1:0]  deficit;
	logic [tbrl_pkg::WAIT_W:0]     hold_sum;
	logic                          sat;
	tbrl_pkg::div_req_t            div_req;
	tbrl_pkg::div_rsp_t            div_rsp;

	tbrl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_comb begin
		cap        = {rate, {tbrl_pkg::TOKEN_FRAC_BITS{1'b0}}};
		refill_sum = {1'b0, store_q} + {1'b0, refill};
		deficit    = need_q - store_q;
		hold_sum   = {1'b0, ceil_q[tbrl_pkg::WAIT_W-1:0]} + {1'b0, hold_q};
		sat        = (|ceil_q[tbrl_pkg::STORE_W:tbrl_pkg::WAIT_W]) || hold_sum[tbrl_pkg::WAIT_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbrl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		res_valid        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = deficit;
		div_req.divisor  = refill;
		case (state_q)
			tbrl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = tbrl_pkg::ST_EVAL;
			end
			tbrl_pkg::ST_EVAL: begin
				if (kind_q == tbrl_pkg::REQ_CONSUME && rate != '0) state_d = tbrl_pkg::ST_CMP;
				else state_d = tbrl_pkg::ST_DONE;
			end
			tbrl_pkg::ST_CMP: begin
				if (need_q <= store_q || refill == '0) begin
					state_d = tbrl_pkg::ST_DONE;
				end else begin
					div_req.start = 1'b1;
					state_d       = tbrl_pkg::ST_DIV;
				end
			end
			tbrl_pkg::ST_DIV: begin
				if (div_rsp.done) state_d = tbrl_pkg::ST_CEIL;
			end
			tbrl_pkg::ST_CEIL: state_d = tbrl_pkg::ST_SUM;
			tbrl_pkg::ST_SUM:  state_d = tbrl_pkg::ST_DONE;
			tbrl_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = tbrl_pkg::ST_IDLE;
			end
			default: state_d = tbrl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			hold_q  <= '0;
		end else begin
			case (state_q)
				tbrl_pkg::ST_EVAL: begin
					if (kind_q == tbrl_pkg::REQ_TICK) begin
						if (hold_q != '0) begin
							hold_q <= hold_q - 1'b1;
						end else if (rate != '0) begin
							store_q <= (refill_sum > {1'b0, cap}) ? cap
								: refill_sum[tbrl_pkg::STORE_W-1:0];
						end
					end else if (rate != '0 && store_q > cap) begin
						store_q <= cap;
					end
				end
				tbrl_pkg::ST_CMP: begin
					if (need_q <= store_q) begin
						store_q <= store_q - need_q;
					end else begin
						store_q <= '0;
						// no refill sets the hold to its maximum, WAIT_MAX
						if (refill == '0) hold_q <= tbrl_pkg::WAIT_MAX;
					end
				end
				tbrl_pkg::ST_SUM: begin
					hold_q <= sat ? tbrl_pkg::WAIT_MAX : hold_sum[tbrl_pkg::WAIT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tbrl_pkg::ST_IDLE: begin
				if (in_valid) begin
					kind_q <= in_kind;
					need_q <= {in_bytes, {tbrl_pkg::TOKEN_FRAC_BITS{1'b0}}};
				end
			end
			tbrl_pkg::ST_EVAL: wait_q <= '0;
			tbrl_pkg::ST_CMP: begin
				if (need_q > store_q && refill == '0) wait_q <= tbrl_pkg::WAIT_MAX;
			end
			tbrl_pkg::ST_CEIL: begin
				ceil_q <= {1'b0, div_rsp.quotient} + {{tbrl_pkg::STORE_W{1'b0}}, div_rsp.rem_nz};
			end
			tbrl_pkg::ST_SUM: begin
				wait_q <= sat ? tbrl_pkg::WAIT_MAX : hold_sum[tbrl_pkg::WAIT_W-1:0];
			end
			default: ;
		endcase
	end

	assign res.wait_ticks  = wait_q;
	assign res.token_level = store_q[tbrl_pkg::STORE_W-1:tbrl_pkg::TOKEN_FRAC_BITS];
	assign res.holding     = hold_q != '0;

	a_tick_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind_q == tbrl_pkg::REQ_TICK) |-> res.wait_ticks == '0)
		else $error("tick word carries a wait");

	a_wait_sets_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.wait_ticks != '0) |-> (hold_q == res.wait_ticks && store_q == '0))
		else $error("deficit wait not reflected in hold and bucket");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> state_q == tbrl_pkg::ST_DIV)
		else $error("divider running outside divide step");

endmodule

// ===== rtl/token_bucket_rate_limiter.sv =====
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tuser: req_type; s_tdata[31:0]: byte_count
// m_        out  m_tvalid/m_tready  m_tdata: wait_ticks, token_level, holding
// cfg_      in   cfg_we             cfg_idx selects register, cfg_wdata value
//
// a tick or unlimited consume steps EVAL, DONE; a granted consume EVAL, CMP, DONE
// a consume in deficit steps EVAL, CMP, the shift-subtract divider, CEIL, SUM, DONE
// s_tready is low from accept until the result moves into the output register
// a result waiting on m_tready does not block the next word from entering
// arst_n clears the bucket, the hold and the control state; refill resets to 256
module token_bucket_rate_limiter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [tbrl_pkg::BYTE_W-1:0]          s_tdata,   // byte_count
	input  logic                                 s_tuser,   // req_type
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// wait_ticks[31:0], token_level[63:32], holding[64], zero pad
	output logic [tbrl_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                 cfg_we,
	input  logic [tbrl_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [tbrl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	logic [tbrl_pkg::BYTE_W-1:0]      rate_q;
	logic [tbrl_pkg::STORE_W-1:0]     refill_q;
	logic                             m_tvalid_q;
	tbrl_pkg::result_t                out_q;
	tbrl_pkg::result_t                res;
	logic                             res_valid;
	logic                             res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= '0;
			refill_q <= tbrl_pkg::REFILL_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				tbrl_pkg::REG_RATE:   rate_q   <= cfg_wdata[tbrl_pkg::BYTE_W-1:0];
				tbrl_pkg::REG_REFILL: refill_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	tbrl_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (tbrl_pkg::req_kind_t'(s_tuser)),
		.in_bytes (s_tdata),
		.rate     (rate_q),
		.refill   (refill_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output word register
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tbrl_pkg::OUT_DATA_W'(out_q);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word taken while busy");

endmodule
